FILE: rtl/kdef_pkg.sv
// Shared types and constants for the key debounce and event-code FIFO block.
// Used by the key update unit, the code FIFO, the top level and the checker.
// No dependencies.
package kdef_pkg;

   // Field widths that the interface fixes.
   localparam int unsigned LEVELS_W  = 4;
   localparam int unsigned CODE_W    = 4;
   localparam int unsigned KEY_ID_W  = 4;
   localparam int unsigned CNT_W     = 5;
   localparam int unsigned FILTER_W  = 4;
   localparam int unsigned TIME_W    = 16;
   localparam int unsigned CSR_DW    = 16;
   localparam int unsigned CSR_AW    = 2;
   localparam int unsigned TDATA_W   = 8;

   // Reset values of the settings and the debounce counters.
   localparam logic [FILTER_W-1:0] FILTER_TIME_RST  = 4'd5;
   localparam logic [TIME_W-1:0]   LONG_TIME_RST    = 16'd100;
   localparam logic [TIME_W-1:0]   REPEAT_SPEED_RST = 16'd0;
   localparam logic [CNT_W-1:0]    DEBOUNCE_RST     = 5'd2;

   // Event code offsets from the key base of three times the key index.
   localparam logic [CODE_W-1:0] CODE_PRESS   = 4'd1;
   localparam logic [CODE_W-1:0] CODE_RELEASE = 4'd2;
   localparam logic [CODE_W-1:0] CODE_LONG    = 4'd3;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_AW-1:0] {
      CSR_FILTER_TIME  = 2'd0,
      CSR_LONG_TIME    = 2'd1,
      CSR_REPEAT_SPEED = 2'd2
   } kdef_csr_idx_type;

   // Stored state of one key.
   typedef struct packed {
      logic [CNT_W-1:0]  debounce_cnt;
      logic              pressed;
      logic [TIME_W-1:0] long_cnt;
      logic [TIME_W-1:0] repeat_cnt;
   } kdef_key_state_type;

   // Settings that the key unit reads.
   typedef struct packed {
      logic [FILTER_W-1:0] filter_time;
      logic [TIME_W-1:0]   long_time;
      logic [TIME_W-1:0]   repeat_speed;
   } kdef_cfg_type;

   // Result of one key update: next state and up to two codes to queue.
   typedef struct packed {
      kdef_key_state_type  next_state;
      logic                push1;
      logic [CODE_W-1:0]   code1;
      logic                push2;
      logic [CODE_W-1:0]   code2;
   } kdef_key_result_type;

   // Control from the sequencer to the code FIFO.
   typedef struct packed {
      logic              push;
      logic [CODE_W-1:0] push_code;
      logic              pop;
   } kdef_fifo_ctl_type;

endpackage

FILE: rtl/kdef_key_unit.sv
// Shared key update unit: debounce, long-press and repeat logic for one key.
// Purely combinational; the sequencer feeds it one key per cycle, pausing for a second push.
// Depends on kdef_pkg.
module kdef_key_unit
   import kdef_pkg::*;
(
   input  logic                key_down,
   input  logic [KEY_ID_W-1:0] key_id,
   input  kdef_key_state_type  cur_state,
   input  kdef_cfg_type        cfg,
   output kdef_key_result_type result
);

   logic [CNT_W-1:0]    filter_lo;
   logic [CNT_W-1:0]    filter_hi;
   logic [CODE_W+1:0]   base_wide;
   logic [CODE_W-1:0]   base;
   logic [TIME_W-1:0]   long_inc;
   logic [TIME_W-1:0]   repeat_inc;
   logic                ev_press;
   logic                ev_second;
   logic [CODE_W-1:0]   second_code;
   kdef_key_state_type  nxt;

   // Code base is three times the key index, kept to the code width.
   assign base_wide  = ({2'b00, key_id} << 1) + {2'b00, key_id};
   assign base       = base_wide[CODE_W-1:0];
   assign filter_lo  = {1'b0, cfg.filter_time};
   assign filter_hi  = {cfg.filter_time, 1'b0};
   assign long_inc   = cur_state.long_cnt + 16'd1;
   assign repeat_inc = cur_state.repeat_cnt + 16'd1;

   // Next state and events for the sampled level.
   always_comb begin
      nxt         = cur_state;
      ev_press    = 1'b0;
      ev_second   = 1'b0;
      second_code = base + CODE_LONG;
      if (key_down) begin
         if (cur_state.debounce_cnt < filter_lo) begin
            nxt.debounce_cnt = filter_lo;
         end else if (cur_state.debounce_cnt < filter_hi) begin
            nxt.debounce_cnt = cur_state.debounce_cnt + 5'd1;
         end else begin
            if (!cur_state.pressed) begin
               nxt.pressed = 1'b1;
               ev_press    = 1'b1;
            end
            if (cfg.long_time != '0) begin
               if (cur_state.long_cnt < cfg.long_time) begin
                  nxt.long_cnt = long_inc;
                  if (long_inc == cfg.long_time) begin
                     ev_second = 1'b1;
                  end
               end else if (cfg.repeat_speed != '0) begin
                  // Repeat phase: a press code each time the count meets the rate.
                  if (repeat_inc == cfg.repeat_speed) begin
                     nxt.repeat_cnt = '0;
                     ev_second      = 1'b1;
                     second_code    = base + CODE_PRESS;
                  end else begin
                     nxt.repeat_cnt = repeat_inc;
                  end
               end
            end
         end
      end else begin
         if (cur_state.debounce_cnt > filter_lo) begin
            nxt.debounce_cnt = filter_lo;
         end else if (cur_state.debounce_cnt != '0) begin
            nxt.debounce_cnt = cur_state.debounce_cnt - 5'd1;
         end else if (cur_state.pressed) begin
            nxt.pressed = 1'b0;
            ev_press    = 1'b1;
            second_code = base + CODE_LONG;
         end
         nxt.long_cnt   = '0;
         nxt.repeat_cnt = '0;
      end
   end

   // A release reuses the first slot; a press may be followed by a second code.
   always_comb begin
      result.next_state = nxt;
      result.push1      = ev_press | ev_second;
      if (ev_press) begin
         result.code1 = key_down ? (base + CODE_PRESS) : (base + CODE_RELEASE);
      end else begin
         result.code1 = second_code;
      end
      result.push2 = ev_press & ev_second;
      result.code2 = second_code;
   end

endmodule

FILE: rtl/kdef_code_fifo.sv
// Event code FIFO: a ring memory with read and write pointers.
// Holds FIFO_DEPTH-1 codes; a push into a full FIFO is dropped, a pop when empty gives 0.
// Depends on kdef_pkg.
module kdef_code_fifo
   import kdef_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  kdef_fifo_ctl_type ctl,
   output logic [CODE_W-1:0] pop_code
);

   localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);

   logic [CODE_W-1:0] mem [FIFO_DEPTH];
   logic [PW-1:0]     wr_ptr_ff;
   logic [PW-1:0]     rd_ptr_ff;
   logic [PW-1:0]     wr_next;
   logic [PW-1:0]     rd_next;
   logic [CODE_W-1:0] pop_code_ff;
   logic              full;
   logic              empty;

   // Pointers wrap at the depth, which need not be a power of two.
   assign wr_next = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
   assign full    = (wr_next == rd_ptr_ff);
   assign empty   = (rd_ptr_ff == wr_ptr_ff);

   // Pointer update and registered read.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (ctl.push && !full) begin
            wr_ptr_ff <= wr_next;
         end
         if (ctl.pop) begin
            if (empty) begin
               pop_code_ff <= '0;
            end else begin
               pop_code_ff <= mem[rd_ptr_ff];
               rd_ptr_ff   <= rd_next;
            end
         end
      end
   end

   // Memory write port.
   always_ff @(posedge clock) begin
      if (ctl.push && !full) begin
         mem[wr_ptr_ff] <= ctl.push_code;
      end
   end

   assign pop_code = pop_code_ff;

endmodule

FILE: rtl/key_debounce_event_fifo.sv
// Key debounce with long press, auto repeat and an event-code FIFO (top level).
// Tick word: keys are updated one per cycle by the shared key unit, with an extra push step
// (S_PUSH2) for each key that queues two codes; ready returns once the last key is done.
// Read word: the code is popped in S_POP and loaded onto rsp in S_DELIVER, as ready returns;
// S_DELIVER waits while an earlier response word is still stalled on rsp.
// Synchronous active-high reset: settings 5/100/0, debounce counts 2, pointers cleared.
// The code memory is not cleared; the pointers never expose an unwritten entry.
module key_debounce_event_fifo
   import kdef_pkg::*;
#(
   parameter int unsigned NUM_KEYS   = 4,
   parameter int unsigned FIFO_DEPTH = 16
)
(
   input  logic                clock,
   input  logic                reset,
   // Request channel.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [TDATA_W-1:0]  req_tdata,   // [3:0] key_levels, [7:4] zero
   input  logic [0:0]          req_tuser,   // [0] op: 0 tick, 1 read
   // Response channel.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TDATA_W-1:0]  rsp_tdata,   // [3:0] key_code, [7:4] zero
   // Configuration port.
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [CSR_DW-1:0]   csr_wdata
);

   localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int unsigned LW = (NUM_KEYS > LEVELS_W) ? NUM_KEYS : LEVELS_W;
   localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_KEY,
      S_PUSH2,
      S_POP,
      S_DELIVER
   } state_type;

   state_type           state_ff;
   logic [KW-1:0]       key_ff;
   logic [LEVELS_W-1:0] levels_ff;
   logic [CODE_W-1:0]   code2_ff;
   logic                rsp_tvalid_ff;
   logic [CODE_W-1:0]   rsp_code_ff;
   kdef_cfg_type        cfg_ff;
   kdef_key_state_type  keys_ff [NUM_KEYS];

   logic [LW-1:0]       levels_ext;
   logic [NUM_KEYS-1:0] down_vec;
   logic                last_key;
   logic                deliver;
   kdef_key_result_type key_in;
   kdef_fifo_ctl_type   fifo_ctl;
   logic [CODE_W-1:0]   pop_code;

   // Keys beyond the sampled field always read as up.
   assign levels_ext = LW'(levels_ff);
   assign down_vec   = levels_ext[NUM_KEYS-1:0];
   assign last_key   = (key_ff == LAST_KEY);

   // A popped code moves to the response register once that register is free.
   assign deliver = (state_ff == S_DELIVER) && (!rsp_tvalid_ff || rsp_tready);

   kdef_key_unit u_key_unit (
      .key_down  (down_vec[key_ff]),
      .key_id    (KEY_ID_W'(key_ff)),
      .cur_state (keys_ff[key_ff]),
      .cfg       (cfg_ff),
      .result    (key_in)
   );

   // FIFO requests from the sequencer.
   always_comb begin
      fifo_ctl.push      = ((state_ff == S_KEY) && key_in.push1) || (state_ff == S_PUSH2);
      fifo_ctl.push_code = (state_ff == S_PUSH2) ? code2_ff : key_in.code1;
      fifo_ctl.pop       = (state_ff == S_POP);
   end

   kdef_code_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_code_fifo (
      .clock    (clock),
      .reset    (reset),
      .ctl      (fifo_ctl),
      .pop_code (pop_code)
   );

   // Sequencer, key state, settings and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         key_ff             <= '0;
         rsp_tvalid_ff      <= 1'b0;
         cfg_ff.filter_time  <= FILTER_TIME_RST;
         cfg_ff.long_time    <= LONG_TIME_RST;
         cfg_ff.repeat_speed <= REPEAT_SPEED_RST;
         for (int i = 0; i < NUM_KEYS; i++) begin
            keys_ff[i].debounce_cnt <= DEBOUNCE_RST;
            keys_ff[i].pressed      <= 1'b0;
            keys_ff[i].long_cnt     <= '0;
            keys_ff[i].repeat_cnt   <= '0;
         end
      end else begin
         // Settings writes; unknown indexes are ignored.
         if (csr_we) begin
            if (csr_addr == CSR_FILTER_TIME) begin
               cfg_ff.filter_time <= csr_wdata[FILTER_W-1:0];
            end
            if (csr_addr == CSR_LONG_TIME) begin
               cfg_ff.long_time <= csr_wdata[TIME_W-1:0];
            end
            if (csr_addr == CSR_REPEAT_SPEED) begin
               cfg_ff.repeat_speed <= csr_wdata[TIME_W-1:0];
            end
         end

         // Response register: load a popped code, or clear once the word is taken.
         if (deliver) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_code_ff   <= pop_code;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  levels_ff <= req_tdata[LEVELS_W-1:0];
                  key_ff    <= '0;
                  state_ff  <= req_tuser[0] ? S_POP : S_KEY;
               end
            end
            S_KEY: begin
               keys_ff[key_ff] <= key_in.next_state;
               if (key_in.push2) begin
                  code2_ff <= key_in.code2;
                  state_ff <= S_PUSH2;
               end else if (last_key) begin
                  state_ff <= S_IDLE;
               end else begin
                  key_ff <= key_ff + 1'b1;
               end
            end
            S_PUSH2: begin
               if (last_key) begin
                  state_ff <= S_IDLE;
               end else begin
                  key_ff   <= key_ff + 1'b1;
                  state_ff <= S_KEY;
               end
            end
            S_POP: begin
               state_ff <= S_DELIVER;
            end
            S_DELIVER: begin
               // Wait until the response register is free.
               if (deliver) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_code_ff);

endmodule

FILE: rtl/kdef_checker.sv
// Port-level checks for key_debounce_event_fifo, attached by the bind below.
// Depends on kdef_pkg.
module kdef_checker
   import kdef_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic [0:0]         req_tuser,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [TDATA_W-1:0] rsp_tdata
);

   logic req_acc;
   assign req_acc = req_tvalid && req_tready;

   // Reset leaves no word on the response side.
   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // Ready is low in the cycle after every accepted word.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("ready right after an accepted word");

   // A tick word never makes a response appear.
   a_tick_silent: assert property (@(posedge clock) disable iff (reset)
      req_acc && !req_tuser[0] && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response after a tick word");

   // Padding bits of the response stay zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[TDATA_W-1:CODE_W] == '0)
      else $error("response padding not zero");

endmodule

bind key_debounce_event_fifo kdef_checker u_kdef_checker (.*);

FILE: dv/tb.sv
// Self-checking testbench for the key debounce and event-code FIFO block.
// Depends on kdef_pkg and key_debounce_event_fifo; it predicts every popped code
// with its own model of the keys and the FIFO and compares it with each response word.
module tb;
   import kdef_pkg::*;

   localparam int unsigned NUM_KEYS      = 4;
   localparam int unsigned FIFO_DEPTH    = 16;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned MAX_REPORTS   = 10;

   // Operation carried in tuser.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_READ = 1'b1;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [TDATA_W-1:0]  req_tdata;   // [3:0] key_levels, [7:4] zero
   logic [0:0]          req_tuser;   // [0] op: 0 tick, 1 read
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [TDATA_W-1:0]  rsp_tdata;   // [3:0] key_code, [7:4] zero
   logic                csr_we;
   logic [CSR_AW-1:0]   csr_addr;
   logic [CSR_DW-1:0]   csr_wdata;

   key_debounce_event_fifo #(
      .NUM_KEYS   (NUM_KEYS),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Model of the settings, the per-key state and the code FIFO.
   logic [FILTER_W-1:0] cfg_filter;
   logic [TIME_W-1:0]   cfg_long;
   logic [TIME_W-1:0]   cfg_repeat;
   logic [CNT_W-1:0]    deb_cnt  [NUM_KEYS];
   logic                is_down  [NUM_KEYS];
   logic [TIME_W-1:0]   hold_cnt [NUM_KEYS];
   logic [TIME_W-1:0]   rpt_cnt  [NUM_KEYS];
   logic [CODE_W-1:0]   code_mem [FIFO_DEPTH];
   int unsigned         rd_ptr;
   int unsigned         wr_ptr;

   logic [CODE_W-1:0]   expected_codes[$];
   int unsigned         mismatches = 0;
   bit                  idle_en = 1'b1;
   int unsigned         reader_hold_cycles = 0;
   int unsigned         reader_stall_left = 0;

   function automatic void init_model();
      cfg_filter = FILTER_TIME_RST;
      cfg_long   = LONG_TIME_RST;
      cfg_repeat = REPEAT_SPEED_RST;
      for (int k = 0; k < NUM_KEYS; k++) begin
         deb_cnt[k]  = DEBOUNCE_RST;
         is_down[k]  = 1'b0;
         hold_cnt[k] = '0;
         rpt_cnt[k]  = '0;
      end
      rd_ptr = 0;
      wr_ptr = 0;
   endfunction

   // A code offered to a full FIFO is lost.
   function automatic void queue_code(input int unsigned code);
      int unsigned nxt;
      nxt = (wr_ptr + 1) % FIFO_DEPTH;
      if (nxt != rd_ptr) begin
         code_mem[wr_ptr] = CODE_W'(code);
         wr_ptr = nxt;
      end
   endfunction

   // An empty FIFO yields the code zero and leaves the pointers alone.
   function automatic logic [CODE_W-1:0] pop_code();
      logic [CODE_W-1:0] code;
      code = '0;
      if (rd_ptr != wr_ptr) begin
         code = code_mem[rd_ptr];
         rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
      end
      return code;
   endfunction

   // Debounce one key and queue the codes that its new state calls for.
   function automatic void update_key(input int unsigned k, input logic down);
      int unsigned cnt;
      int unsigned ft;
      int unsigned base;
      cnt  = deb_cnt[k];
      ft   = cfg_filter;
      base = 3 * k;
      if (down) begin
         if (cnt < ft) begin
            deb_cnt[k] = CNT_W'(ft);
         end else if (cnt < 2 * ft) begin
            deb_cnt[k] = CNT_W'(cnt + 1);
         end else begin
            if (!is_down[k]) begin
               is_down[k] = 1'b1;
               queue_code(base + CODE_PRESS);
            end
            if (cfg_long != '0) begin
               if (hold_cnt[k] < cfg_long) begin
                  hold_cnt[k] = hold_cnt[k] + 1'b1;
                  if (hold_cnt[k] == cfg_long) begin
                     queue_code(base + CODE_LONG);
                  end
               end else if (cfg_repeat != '0) begin
                  // The repeat counter wraps at its width if the rate was lowered under it.
                  rpt_cnt[k] = rpt_cnt[k] + 1'b1;
                  if (rpt_cnt[k] == cfg_repeat) begin
                     rpt_cnt[k] = '0;
                     queue_code(base + CODE_PRESS);
                  end
               end
            end
         end
      end else begin
         if (cnt > ft) begin
            deb_cnt[k] = CNT_W'(ft);
         end else if (cnt != 0) begin
            deb_cnt[k] = CNT_W'(cnt - 1);
         end else if (is_down[k]) begin
            is_down[k] = 1'b0;
            queue_code(base + CODE_RELEASE);
         end
         hold_cnt[k] = '0;
         rpt_cnt[k]  = '0;
      end
   endfunction

   function automatic void model_tick(input logic [LEVELS_W-1:0] levels);
      for (int k = 0; k < NUM_KEYS; k++) begin
         update_key(k, (k < LEVELS_W) ? levels[k] : 1'b0);
      end
   endfunction

   function automatic void report_mismatch(input string what, input int exp_val,
                                           input int act_val);
      if (mismatches < MAX_REPORTS) begin
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_val, act_val);
      end
      mismatches++;
   endfunction

   // Clock; the one reset at the start is driven by the main sequence.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Drop valid and let the given number of cycles pass.
   task automatic park_request(input int unsigned cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Offer one word, wait for its acceptance and update the model with it.
   // Valid stays high afterward so that back-to-back words need no extra step.
   task automatic send_word(input logic op, input logic [LEVELS_W-1:0] levels);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         park_request($urandom_range(1, 7));
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(TDATA_W - LEVELS_W){1'b0}}, levels};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_READ) begin
         expected_codes.push_back(pop_code());
      end else begin
         model_tick(levels);
      end
   endtask

   // Wait until every expected code has come back and a tick in flight has finished.
   task automatic settle();
      park_request(1);
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers on consecutive edges while the block is idle.
   task automatic set_config(input int unsigned filter, input int unsigned long_ticks,
                             input int unsigned repeat_ticks);
      settle();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_FILTER_TIME;
      csr_wdata <= CSR_DW'(filter);
      @(posedge clock);
      csr_addr  <= CSR_LONG_TIME;
      csr_wdata <= CSR_DW'(long_ticks);
      @(posedge clock);
      csr_addr  <= CSR_REPEAT_SPEED;
      csr_wdata <= CSR_DW'(repeat_ticks);
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_filter = FILTER_W'(filter);
      cfg_long   = TIME_W'(long_ticks);
      cfg_repeat = TIME_W'(repeat_ticks);
      @(posedge clock);
   endtask

   // A read straight after reset finds the FIFO empty.
   task automatic test_empty_read();
      send_word(OP_READ, LEVELS_W'($urandom_range(0, 15)));
   endtask

   // All keys held under the reset settings until each press is confirmed.
   task automatic test_default_press();
      repeat (7) send_word(OP_TICK, 4'hF);
   endtask

   // Zero filter time confirms at once; the codes overflow the FIFO, then it is drained
   // past empty.
   task automatic test_zero_filter_overflow();
      set_config(0, 1, 1);
      send_word(OP_TICK, 4'hF);
      send_word(OP_TICK, 4'hF);
      send_word(OP_TICK, 4'h0);
      send_word(OP_TICK, 4'h0);
      for (int i = 0; i <= FIFO_DEPTH; i++) begin
         send_word(OP_READ, (i % 2 == 0) ? 4'h0 : 4'hF);
      end
   endtask

   // Lower the repeat rate under a running repeat count; the count runs on past the
   // rate and no repeat code is queued.
   task automatic test_repeat_rate_lowered();
      idle_en = 1'b0;
      set_config(1, 2, 10);
      repeat (9) send_word(OP_TICK, 4'h1);
      set_config(1, 2, 2);
      repeat (40) send_word(OP_TICK, 4'h1);
      repeat (8) send_word(OP_READ, 4'h0);
      idle_en = 1'b1;
   endtask

   // The reader holds off for a long stretch while reads keep coming.
   task automatic test_backpressure();
      set_config(2, 4, 1);
      repeat (12) send_word(OP_TICK, 4'hA);
      reader_hold_cycles = 300;
      repeat (24) send_word(OP_READ, LEVELS_W'($urandom_range(0, 15)));
   endtask

   // Keys go down and up with random hold times and occasional contact bounce,
   // mixed with reads.
   task automatic run_random_phase(input int unsigned items);
      logic [LEVELS_W-1:0] target;
      logic [LEVELS_W-1:0] bounce;
      int unsigned         span;
      target = LEVELS_W'($urandom_range(0, 15));
      span   = 2 * cfg_filter + ((cfg_long > 30) ? 30 : cfg_long) + 3;
      repeat (items) begin
         if ($urandom_range(0, 99) < 30) begin
            send_word(OP_READ, LEVELS_W'($urandom_range(0, 15)));
         end else begin
            for (int k = 0; k < LEVELS_W; k++) begin
               if ($urandom_range(0, span - 1) == 0) begin
                  target[k] = ~target[k];
               end
            end
            bounce = ($urandom_range(0, 9) == 0) ? LEVELS_W'($urandom_range(1, 15)) : '0;
            send_word(OP_TICK, target ^ bounce);
         end
      end
   endtask

   // Several settings in turn, extremes among them; the last phases run without idling.
   task automatic test_random_mix();
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_config(5, 100, 0);
            1: set_config(1, 3, 2);
            2: set_config(15, 20, 5);
            3: set_config(0, 1, 1);
            4: set_config(3, 0, 4);
            5: set_config(2, 65535, 65535);
            6: set_config(1, 6, 0);
            default: set_config($urandom_range(0, 15), $urandom_range(0, 40),
                                $urandom_range(0, 8));
         endcase
         idle_en = (p % 3 != 2) && (p < 6);
         run_random_phase(150);
      end
   endtask

   // Main sequence.
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_TICK;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_FILTER_TIME;
      csr_wdata  <= '0;
      init_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_read();
      test_default_press();
      test_zero_filter_overflow();
      test_repeat_rate_lowered();
      test_backpressure();
      test_random_mix();

      settle();
      if (mismatches == 0 && expected_codes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Reader: long hold-offs on request, otherwise short random stalls while idle_en is set.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reader_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            reader_hold_cycles--;
         end else if (reader_stall_left > 0) begin
            rsp_tready <= 1'b0;
            reader_stall_left--;
         end else if (idle_en && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            reader_stall_left = $urandom_range(0, 6);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each accepted response word with the oldest predicted code.
   always @(posedge clock) begin
      logic [CODE_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_codes.size() == 0) begin
            report_mismatch("unexpected key_code", -1, rsp_tdata[CODE_W-1:0]);
         end else begin
            want = expected_codes.pop_front();
            if (rsp_tdata[CODE_W-1:0] !== want) begin
               report_mismatch("key_code", want, rsp_tdata[CODE_W-1:0]);
            end
         end
      end
   end

   // Watchdog.
   initial begin
      #50_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
